>>> hdl/poe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package poe_pkg;

	localparam int MAX_ELEMENTS = 4096;
	localparam int NIDX_W       = 12;
	localparam int ORD_W        = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W        = (CNT_W > NIDX_W) ? CNT_W : NIDX_W;
	localparam int K_W          = $clog2(CNT_W);
	localparam int DCNT_W       = $clog2(CNT_W + 1);
	localparam int PROD_W       = ORD_W + CNT_W;

	typedef struct packed {
		logic [NIDX_W-1:0] next_index;
		logic              last;
	} poe_req_t;

	typedef struct packed {
		logic [ORD_W-1:0] order;
		logic             overflow;
		logic             not_permutation;
	} poe_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_CHECK,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_WALK,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} poe_state_t;

	typedef struct packed {
		logic set_init;
		logic clear;
		logic load;
		logic check;
		logic scan_init;
		logic scan_next;
		logic walk_init;
		logic walk_step;
		logic gcd_load;
		logic gcd_step;
		logic div_load;
		logic div_step;
		logic mul;
		logic upd;
	} poe_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic bad;
		logic scan_end;
		logic vis_hit;
		logic walk_end;
	} poe_dp_sts_t;

	typedef struct packed {
		logic gcd_eq;
		logic div_last;
		logic prod_ovf;
	} poe_lcm_sts_t;

endpackage

`default_nettype wire

>>> hdl/poe_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module poe_dp import poe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  poe_cmd_t         cmd,
	input  poe_req_t         req,
	output poe_dp_sts_t      sts,
	output logic [CNT_W-1:0] cyc_len,
	output logic             bad
);

	logic [NIDX_W-1:0] perm_mem [MAX_ELEMENTS];
	logic              seen_mem [MAX_ELEMENTS];
	logic              visited_mem [MAX_ELEMENTS];

	logic [IDX_W-1:0]  clr_addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  scan_i_q;
	logic [CNT_W-1:0]  len_q;
	logic [NIDX_W-1:0] max_q;
	logic [NIDX_W-1:0] perm_rd_q;
	logic              set_bad_q;
	logic              first_q;
	logic              bad_q;
	logic              vis_rd_q;
	logic              chk_s1;
	logic              seen_rd_s1;

	logic              in_range;
	logic              store_en;
	logic              seen_dup;
	logic              seen_we;
	logic              vis_we;
	logic [IDX_W-1:0]  seen_addr;
	logic [IDX_W-1:0]  walk_addr;
	logic [IDX_W-1:0]  vis_addr;

	assign in_range  = CMP_W'(req.next_index) < CMP_W'(MAX_ELEMENTS);
	assign store_en  = cmd.load & in_range & (cnt_q < CNT_W'(MAX_ELEMENTS));
	assign seen_dup  = chk_s1 & seen_rd_s1;
	assign seen_we   = cmd.clear | store_en;
	assign seen_addr = cmd.clear ? clr_addr_q : IDX_W'(req.next_index);
	assign walk_addr = first_q ? scan_i_q[IDX_W-1:0] : IDX_W'(perm_rd_q);
	assign vis_we    = cmd.clear | cmd.walk_step;
	assign vis_addr  = cmd.clear ? clr_addr_q :
	                   (cmd.walk_step ? walk_addr : scan_i_q[IDX_W-1:0]);

	// read-before-write: seen_rd_s1 gets the old mark
	always_ff @(posedge clk) begin
		if (seen_we)
			seen_mem[seen_addr] <= !cmd.clear;
		seen_rd_s1 <= seen_mem[seen_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			visited_mem[vis_addr] <= !cmd.clear;
		vis_rd_q <= visited_mem[vis_addr];
	end

	always_ff @(posedge clk) begin
		if (store_en)
			perm_mem[cnt_q[IDX_W-1:0]] <= req.next_index;
		if (cmd.walk_step)
			perm_rd_q <= perm_mem[walk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			cnt_q      <= '0;
			max_q      <= '0;
			set_bad_q  <= 1'b0;
			chk_s1     <= 1'b0;
			scan_i_q   <= '0;
			first_q    <= 1'b0;
			len_q      <= '0;
			bad_q      <= 1'b0;
		end else begin
			chk_s1 <= store_en;
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (cmd.set_init) begin
				cnt_q     <= '0;
				max_q     <= '0;
				set_bad_q <= 1'b0;
			end else begin
				if (store_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (req.next_index > max_q)
						max_q <= req.next_index;
				end
				if (seen_dup || (cmd.load && !store_en))
					set_bad_q <= 1'b1;
			end
			if (cmd.check)
				bad_q <= sts.bad;
			if (cmd.scan_init)
				scan_i_q <= '0;
			else if (cmd.scan_next)
				scan_i_q <= scan_i_q + CNT_W'(1);
			if (cmd.walk_init) begin
				first_q <= 1'b1;
				len_q   <= '0;
			end else if (cmd.walk_step) begin
				first_q <= 1'b0;
				len_q   <= len_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		sts.clear_last = clr_addr_q == IDX_W'(MAX_ELEMENTS - 1);
		sts.bad        = set_bad_q | seen_dup | (cnt_q == '0) |
		                 (CMP_W'(max_q) >= CMP_W'(cnt_q));
		sts.scan_end   = scan_i_q == cnt_q;
		sts.vis_hit    = vis_rd_q;
		sts.walk_end   = !first_q && (IDX_W'(perm_rd_q) == scan_i_q[IDX_W-1:0]);
	end

	assign cyc_len = len_q;
	assign bad     = bad_q;

endmodule

`default_nettype wire

>>> hdl/poe_lcm.sv
`timescale 1ns / 1ps
`default_nettype none

module poe_lcm import poe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  poe_cmd_t         cmd,
	input  logic [CNT_W-1:0] cyc_len,
	output poe_lcm_sts_t     sts,
	output logic [ORD_W-1:0] order,
	output logic             sat
);

	logic [ORD_W-1:0]  ord_q;
	logic              sat_q;
	logic [ORD_W-1:0]  a_q;
	logic [CNT_W-1:0]  b_q;
	logic [K_W-1:0]    k_q;
	logic [CNT_W-1:0]  g_q;
	logic [CNT_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [PROD_W-1:0] prod_q;

	logic [CNT_W:0]    trial;
	logic              qbit;
	logic              a_gt;

	assign trial = {rem_q, dvd_q[CNT_W-1]};
	assign qbit  = trial >= {1'b0, g_q};
	assign a_gt  = a_q > ORD_W'(b_q);

	// binary gcd, one step a cycle
	always_ff @(posedge clk) begin
		if (cmd.gcd_load) begin
			a_q <= ord_q;
			b_q <= cyc_len;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + K_W'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_gt) begin
				a_q <= (a_q - ORD_W'(b_q)) >> 1;
			end else begin
				b_q <= (b_q - CNT_W'(a_q)) >> 1;
			end
		end
	end

	// restoring divide: cycle length / gcd
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			g_q   <= b_q << k_q;
			dvd_q <= cyc_len;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? CNT_W'(trial - {1'b0, g_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[CNT_W-2:0], qbit};
		end
		if (cmd.mul)
			prod_q <= PROD_W'(ord_q) * PROD_W'(dvd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q  <= ORD_W'(1);
			sat_q  <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.div_load)
				dcnt_q <= DCNT_W'(CNT_W);
			else if (cmd.div_step)
				dcnt_q <= dcnt_q - DCNT_W'(1);
			if (cmd.set_init) begin
				ord_q <= ORD_W'(1);
				sat_q <= 1'b0;
			end else if (cmd.upd) begin
				if (sts.prod_ovf) begin
					ord_q <= '1;
					sat_q <= 1'b1;
				end else begin
					ord_q <= prod_q[ORD_W-1:0];
				end
			end
		end
	end

	always_comb begin
		sts.gcd_eq   = a_q == ORD_W'(b_q);
		sts.div_last = dcnt_q == DCNT_W'(1);
		sts.prod_ovf = |prod_q[PROD_W-1:ORD_W];
	end

	assign order = ord_q;
	assign sat   = sat_q;

endmodule

`default_nettype wire

>>> hdl/poe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module poe_ctrl import poe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         last,
	input  poe_dp_sts_t  dp_sts,
	input  poe_lcm_sts_t lcm_sts,
	output poe_cmd_t     cmd,
	output logic         busy,
	output logic         done
);

	poe_state_t state_q;
	poe_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (dp_sts.clear_last)
					state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				if (start && last)
					state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				state_nx = dp_sts.bad ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				state_nx = dp_sts.scan_end ? ST_DONE : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_nx = dp_sts.vis_hit ? ST_SCAN : ST_WALK;
			end
			ST_WALK: begin
				if (dp_sts.walk_end)
					state_nx = ST_GCD;
			end
			ST_GCD: begin
				if (lcm_sts.gcd_eq)
					state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (lcm_sts.div_last)
					state_nx = ST_MUL;
			end
			ST_MUL: begin
				state_nx = ST_UPD;
			end
			ST_UPD: begin
				state_nx = lcm_sts.prod_ovf ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				state_nx = ST_CLEAR;
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear    = 1'b1;
				cmd.set_init = 1'b1;
			end
			ST_LOAD: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CHECK: begin
				cmd.check     = 1'b1;
				cmd.scan_init = !dp_sts.bad;
			end
			ST_SCAN: begin
			end
			ST_SCAN_CHK: begin
				cmd.scan_next = dp_sts.vis_hit;
				cmd.walk_init = !dp_sts.vis_hit;
			end
			ST_WALK: begin
				cmd.gcd_load  = dp_sts.walk_end;
				cmd.walk_step = !dp_sts.walk_end;
			end
			ST_GCD: begin
				cmd.div_load = lcm_sts.gcd_eq;
				cmd.gcd_step = !lcm_sts.gcd_eq;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_UPD: begin
				cmd.upd       = 1'b1;
				cmd.scan_next = !lcm_sts.prod_ovf;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/permutation_order_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// request   start & !busy accepts     req    : poe_req_t (next_index, last)
// result    done, one cycle, no stall result : poe_rsp_t (order, overflow, not_permutation)
//
// Entries load one per cycle while busy is low; an entry with last closes the set.
// After the last entry: a check, then a scan over the indices; each index not yet visited
// walks its cycle to find its length, then a binary gcd, a restoring divide, a multiply
// and an update fold that length into the order. A bad set or a saturated order skips to the result.
// The result strobes for one cycle, then a clearing pass over the mark
// memories runs with busy high; the same pass runs after reset. The receiver cannot stall.
module permutation_order_engine import poe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  poe_req_t req,
	output logic     busy,
	output logic     done,
	output poe_rsp_t result
);

	poe_cmd_t         cmd;
	poe_dp_sts_t      dp_sts;
	poe_lcm_sts_t     lcm_sts;
	logic [CNT_W-1:0] cyc_len;
	logic             bad;
	logic [ORD_W-1:0] order;
	logic             sat;

	poe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last    (req.last),
		.dp_sts  (dp_sts),
		.lcm_sts (lcm_sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	poe_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.sts     (dp_sts),
		.cyc_len (cyc_len),
		.bad     (bad)
	);

	poe_lcm u_lcm (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cyc_len (cyc_len),
		.sts     (lcm_sts),
		.order   (order),
		.sat     (sat)
	);

	assign result.order           = bad ? ORD_W'(1) : order;
	assign result.overflow        = !bad & sat;
	assign result.not_permutation = bad;

endmodule

`default_nettype wire

>>> bench/order_checker.sv
`timescale 1ns / 1ps

module order_checker import poe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  poe_req_t req,
	input  logic     done,
	input  poe_rsp_t result,
	output int       errors,
	output int       pending
);

	logic [NIDX_W-1:0] images [MAX_ELEMENTS];
	bit                seen   [MAX_ELEMENTS];
	bit                walked [MAX_ELEMENTS];
	int unsigned       entry_cnt;
	int unsigned       max_image;
	bit                set_bad;
	int                fail_cnt;
	poe_rsp_t          expected_orders[$];
	poe_rsp_t          head;

	assign errors = fail_cnt;

	task automatic clear_set();
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			seen[i]   = 1'b0;
			walked[i] = 1'b0;
		end
		entry_cnt = 0;
		max_image = 0;
		set_bad   = 1'b0;
	endtask

	// order of the set = lcm of its cycle lengths, saturating at 32 bits
	task automatic fold_entry(input logic [NIDX_W-1:0] v, input logic closes);
		poe_rsp_t          rsp;
		int unsigned       j;
		int unsigned       len;
		longint unsigned   ord;
		longint unsigned   a;
		longint unsigned   b;
		longint unsigned   r;
		longint unsigned   prod;
		bit                sat;
		if (entry_cnt >= MAX_ELEMENTS) begin
			set_bad = 1'b1;
		end else begin
			if (seen[v])
				set_bad = 1'b1;
			seen[v] = 1'b1;
			images[entry_cnt] = v;
			entry_cnt++;
			if (v > max_image)
				max_image = v;
		end
		if (!closes)
			return;
		if (entry_cnt == 0 || max_image >= entry_cnt)
			set_bad = 1'b1;
		rsp.order           = 32'd1;
		rsp.overflow        = 1'b0;
		rsp.not_permutation = 1'b1;
		if (!set_bad) begin
			ord = 1;
			sat = 1'b0;
			for (int i = 0; i < entry_cnt; i++) begin
				if (walked[i])
					continue;
				j   = i;
				len = 0;
				do begin
					walked[j] = 1'b1;
					len++;
					j = images[j];
				end while (j != i && j < entry_cnt && len <= entry_cnt);
				if (!sat) begin
					a = ord;
					b = len;
					while (b != 0) begin
						r = a % b;
						a = b;
						b = r;
					end
					prod = (ord / a) * len;
					if (prod > 64'hFFFF_FFFF) begin
						sat = 1'b1;
						ord = 64'hFFFF_FFFF;
					end else begin
						ord = prod;
					end
				end
			end
			rsp.order           = ord[ORD_W-1:0];
			rsp.overflow        = sat;
			rsp.not_permutation = 1'b0;
		end
		expected_orders.insert(expected_orders.size(), rsp);
		clear_set();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			expected_orders.delete();
			fail_cnt = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_orders.size() == 0) begin
					$error("unexpected result: order %0d overflow %0b not_permutation %0b",
						result.order, result.overflow, result.not_permutation);
					fail_cnt++;
				end else begin
					head = expected_orders.pop_front();
					if (result.order !== head.order) begin
						$error("order: expected %0d, got %0d", head.order, result.order);
						fail_cnt++;
					end
					if (result.overflow !== head.overflow) begin
						$error("overflow: expected %0b, got %0b", head.overflow,
							result.overflow);
						fail_cnt++;
					end
					if (result.not_permutation !== head.not_permutation) begin
						$error("not_permutation: expected %0b, got %0b",
							head.not_permutation, result.not_permutation);
						fail_cnt++;
					end
				end
			end
			if (start && !busy)
				fold_entry(req.next_index, req.last);
			pending <= expected_orders.size();
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import poe_pkg::*;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	poe_req_t req    = '0;
	logic     busy;
	logic     done;
	poe_rsp_t result;
	int       errors;
	int       pending;

	logic [NIDX_W-1:0] set_q[$];
	bit                idle_on;
	int                items_sent;
	int                sets_sent;

	always #5 clk = ~clk;

	permutation_order_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	order_checker watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	task automatic send_entry(input logic [NIDX_W-1:0] v, input logic closes);
		poe_req_t r;
		while (idle_on && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
		r.next_index = v;
		r.last       = closes;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_set();
		foreach (set_q[k])
			send_entry(set_q[k], k == set_q.size() - 1);
		sets_sent++;
	endtask

	task automatic build_shuffle(input int n);
		int                j;
		logic [NIDX_W-1:0] t;
		set_q.delete();
		for (int k = 0; k < n; k++)
			set_q.insert(set_q.size(), NIDX_W'(k));
		for (int k = n - 1; k > 0; k--) begin
			j        = int'($urandom_range(k));
			t        = set_q[k];
			set_q[k] = set_q[j];
			set_q[j] = t;
		end
	endtask

	// disjoint cycles of chosen lengths; all small primes push lcm past 32 bits
	task automatic build_cycles(input bit want_sat);
		int                primes[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
		int                lens[$];
		int                n;
		int                p;
		logic [NIDX_W-1:0] slots[$];
		n = 0;
		foreach (primes[i])
			if (want_sat || $urandom_range(99) < 60)
				lens.insert(lens.size(), primes[i]);
		repeat ($urandom_range(3))
			lens.insert(lens.size(), int'($urandom_range(1, 12)));
		if (lens.size() == 0)
			lens.insert(lens.size(), 1);
		foreach (lens[i])
			n += lens[i];
		build_shuffle(n);
		slots = set_q;
		p = 0;
		foreach (lens[i]) begin
			for (int k = 0; k < lens[i]; k++)
				set_q[slots[p + k]] = slots[p + (k + 1) % lens[i]];
			p += lens[i];
		end
	endtask

	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n;
		int k;
		int m;
		int pick;
		int set_no;
		idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_q = '{12'd0};                      send_set();
		set_q = '{12'd1, 12'd0};               send_set();
		set_q = '{12'd1, 12'd2, 12'd0};        send_set();
		set_q = '{12'd2, 12'd0, 12'd1, 12'd3}; send_set();
		set_q = '{12'd0, 12'd0};               send_set();
		set_q = '{12'd4095, 12'd0};            send_set();
		set_q = '{12'd3, 12'd2, 12'd1, 12'd0, 12'd4}; send_set();
		set_q = '{12'd1, 12'd0, 12'd3, 12'd2, 12'd0}; send_set();

		items_sent = 0;
		sets_sent  = 0;
		set_no     = 0;
		while (items_sent < 1250 || sets_sent < 60) begin
			idle_on = !(set_no >= 25 && set_no < 40);
			pick    = int'($urandom_range(99));
			if (set_no == 15) begin
				build_shuffle(MAX_ELEMENTS);
			end else if (set_no == 35) begin
				// one entry more than the store holds
				build_shuffle(MAX_ELEMENTS);
				set_q.insert(set_q.size(), NIDX_W'($urandom_range(4095)));
			end else if (pick < 55) begin
				build_shuffle(int'($urandom_range(1, 32)));
			end else if (pick < 68) begin
				build_cycles($urandom_range(3) == 0);
			end else if (pick < 88) begin
				n = int'($urandom_range(2, 32));
				build_shuffle(n);
				k = int'($urandom_range(n - 1));
				if ($urandom_range(1)) begin
					m        = (k + int'($urandom_range(1, n - 1))) % n;
					set_q[k] = set_q[m];
				end else begin
					set_q[k] = NIDX_W'($urandom_range(n, 4095));
				end
			end else begin
				set_q.delete();
				repeat ($urandom_range(1, 8))
					set_q.insert(set_q.size(), NIDX_W'($urandom_range(4095)));
			end
			send_set();
			set_no++;
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (5000) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
